// File: sv/sprq_pkg.sv
// Shared types and codes for the sorted priority queue.
`timescale 1ns / 1ps
`default_nettype none

package sprq_pkg;

    // Stored word type
    typedef logic signed [31:0] t_word;

    // Operation codes carried in the low bits of the input word
    localparam logic [1:0] MODE_PUSH = 2'd0;
    localparam logic [1:0] MODE_POP  = 2'd1;
    localparam logic [1:0] MODE_PEEK = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Payload widths on the stream ports (fields packed, padded to bytes)
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    // Broadcast control from the queue controller to every cell
    typedef struct packed {
        logic  push_en;
        logic  pop_en;
        t_word value;
    } t_cell_ctl;

endpackage

`default_nettype wire

// File: sv/sprq_cell.sv
// One compare-and-shift cell of the sorted queue row.
`timescale 1ns / 1ps
`default_nettype none

module sprq_cell
    import sprq_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_cell_ctl i_ctl,
    input  wire logic      i_valid,       // this cell holds a live entry
    input  wire t_word     i_left_value,  // neighbor toward the head
    input  wire logic      i_left_gt,     // left neighbor is live and > push value
    input  wire t_word     i_right_value, // neighbor toward the tail
    output t_word          o_value,
    output logic           o_gt
);

    t_word r_value;
    t_word n_value;
    logic  w_own_gt;

    // strict compare keeps equal entries ahead of the new one
    assign w_own_gt = (!i_valid) || (r_value > i_ctl.value);
    assign o_gt     = i_valid && (r_value > i_ctl.value);
    assign o_value  = r_value;

    always_comb begin
        priority if (i_ctl.push_en) begin
            priority if (i_left_gt) begin
                n_value = i_left_value;
            end else if (w_own_gt) begin
                n_value = i_ctl.value;
            end else begin
                n_value = r_value;
            end
        end else if (i_ctl.pop_en) begin
            n_value = i_right_value;
        end else begin
            n_value = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

`default_nettype wire

// File: sv/sorted_priority_queue.sv
// Top level of the min-first sorted priority queue.
`timescale 1ns / 1ps
`default_nettype none

// Min-first priority queue of signed 32-bit values held in ascending order
// in a row of DEPTH compare-and-shift cells. Each input word carries an
// operation: push inserts the value at its sorted place (after equal
// values), pop removes and returns the smallest, peek returns it without
// removing it. Every operation gives exactly one result word with the
// value (zero unless a pop or peek succeeded), a status (ok, push dropped
// because full, pop/peek on empty), the entry count after the operation
// and an empty flag. Unused mode 3 is a no-op reporting status ok.
// Throughput is one word per clock while the output is not stalled: all
// cells compare against the pushed value and shift toward their neighbor
// in the same edge. The result is registered and appears in the cycle
// after the input word is accepted; a new word is accepted whenever the
// result register is empty or being drained in that cycle. Reset clears
// count and output valid; cell contents beyond the count are never read.
module sorted_priority_queue
    import sprq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // slave side
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // mode[1:0], value[33:2], zero pad
    // master side
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata    // out_value[31:0], status[33:32],
                                                 // count[38:34], is_empty[39]
);

    localparam int CW = $clog2(DEPTH + 1);

    // Input word fields
    logic [1:0] w_mode;
    t_word      w_in_value;
    logic       w_accept;

    assign w_mode     = s_tdata[1:0];
    assign w_in_value = s_tdata[33:2];

    // Occupancy
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          w_full;
    logic          w_empty;

    assign w_full  = (r_count == CW'(DEPTH));
    assign w_empty = (r_count == '0);

    // Output register
    logic                 r_m_tvalid;
    logic [M_TDATA_W-1:0] r_m_tdata;
    logic [M_TDATA_W-1:0] n_m_tdata;

    assign s_tready = (!r_m_tvalid) || m_tready;
    assign w_accept = s_tvalid && s_tready;
    assign m_tvalid = r_m_tvalid;
    assign m_tdata  = r_m_tdata;

    // Cell row
    t_cell_ctl w_ctl;
    t_word     w_cell_value [DEPTH];
    logic      w_cell_gt    [DEPTH];

    // Result fields for the word being accepted
    t_word      w_res_value;
    logic [1:0] w_res_status;

    always_comb begin
        w_ctl.push_en = 1'b0;
        w_ctl.pop_en  = 1'b0;
        w_ctl.value   = w_in_value;
        w_res_value   = '0;
        w_res_status  = ST_OK;
        n_count       = r_count;
        if (w_accept) begin
            unique case (w_mode)
                MODE_PUSH: begin
                    if (w_full) begin
                        w_res_status = ST_FULL;
                    end else begin
                        w_ctl.push_en = 1'b1;
                        n_count       = r_count + CW'(1);
                    end
                end
                MODE_POP: begin
                    if (w_empty) begin
                        w_res_status = ST_EMPTY;
                    end else begin
                        w_ctl.pop_en = 1'b1;
                        w_res_value  = w_cell_value[0];
                        n_count      = r_count - CW'(1);
                    end
                end
                MODE_PEEK: begin
                    if (w_empty) begin
                        w_res_status = ST_EMPTY;
                    end else begin
                        w_res_value = w_cell_value[0];
                    end
                end
                default: begin
                    // unused code: no-op
                end
            endcase
        end
    end

    // Pack result word; count reported in 5 bits
    always_comb begin
        n_m_tdata        = '0;
        n_m_tdata[31:0]  = w_res_value;
        n_m_tdata[33:32] = w_res_status;
        n_m_tdata[38:34] = 5'(n_count);
        n_m_tdata[39]    = (n_count == '0);
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            t_word w_left;
            logic  w_left_gt;
            t_word w_right;
            if (gi == 0) begin : g_head
                assign w_left    = '0;
                assign w_left_gt = 1'b0;
            end else begin : g_mid
                assign w_left    = w_cell_value[gi-1];
                assign w_left_gt = w_cell_gt[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_tail
                assign w_right = w_cell_value[gi];
            end else begin : g_body
                assign w_right = w_cell_value[gi+1];
            end
            sprq_cell u_cell (
                .i_clk         (i_clk),
                .i_ctl         (w_ctl),
                .i_valid       (CW'(gi) < r_count),
                .i_left_value  (w_left),
                .i_left_gt     (w_left_gt),
                .i_right_value (w_right),
                .o_value       (w_cell_value[gi]),
                .o_gt          (w_cell_gt[gi])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_m_tvalid <= 1'b1;
            end else if (m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    // payload register, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_m_tdata <= n_m_tdata;
        end
    end

endmodule

`default_nettype wire

// File: test/sprq_monitor.sv
// Watches both stream channels of the priority queue, predicts and compares every result word.
`timescale 1ns / 1ps

module sprq_monitor
    import sprq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    input  wire logic                 i_s_tready,
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,   // mode[1:0], value[33:2], zero pad
    input  wire logic                 i_m_tvalid,
    input  wire logic                 i_m_tready,
    input  wire logic [M_TDATA_W-1:0] i_m_tdata,   // out_value, status, count, is_empty
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_results,
    output int                        o_full_drops,
    output int                        o_empty_reads
);

    // Result word layout, lowest field last in the declaration
    typedef struct packed {
        logic       is_empty;
        logic [4:0] count;
        logic [1:0] status;
        t_word      out_value;
    } t_queue_result;

    t_word         held_vals[$];       // predicted queue contents, ascending
    t_queue_result pending_results[$]; // expected result words, oldest first
    int            fail_count    = 0;
    int            result_count  = 0;
    int            full_drops    = 0;
    int            empty_reads   = 0;

    // Applies one operation to the predicted contents and returns its result word.
    function automatic t_queue_result apply_queue_op(input logic [1:0] mode, input t_word value);
        t_queue_result r;
        int            slot;
        r = '0;
        r.status = ST_OK;
        if (mode == MODE_PUSH) begin
            if (held_vals.size() >= DEPTH) begin
                r.status = ST_FULL;
                full_drops++;
            end else begin
                // new value lands after any equal ones
                slot = held_vals.size();
                while (slot > 0 && held_vals[slot-1] > value)
                    slot--;
                held_vals.insert(slot, value);
            end
        end else if (mode == MODE_POP || mode == MODE_PEEK) begin
            if (held_vals.size() == 0) begin
                r.status = ST_EMPTY;
                empty_reads++;
            end else if (mode == MODE_POP) begin
                r.out_value = held_vals.pop_front();
            end else begin
                r.out_value = held_vals[0];
            end
        end
        // count travels in 5 bits
        r.count    = 5'(held_vals.size());
        r.is_empty = (held_vals.size() == 0);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_queue_result got;
        t_queue_result want;
        if (!i_rst_n) begin
            held_vals.delete();
            pending_results.delete();
        end else begin
            // prediction goes in first; with a registered output the word seen
            // at this edge always belongs to an earlier input
            if (i_s_tvalid && i_s_tready)
                pending_results.push_back(apply_queue_op(i_s_tdata[1:0], i_s_tdata[33:2]));
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata;
                result_count++;
                if (pending_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result word: expected none, actual %0h",
                             $time, got);
                end else begin
                    want = pending_results.pop_front();
                    check_field("out_value", want.out_value, got.out_value);
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("count", 32'(want.count), 32'(got.count));
                    check_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
                end
            end
        end
        o_fail_count  <= fail_count;
        o_pending     <= pending_results.size();
        o_results     <= result_count;
        o_full_drops  <= full_drops;
        o_empty_reads <= empty_reads;
    end

endmodule

// File: test/tb_sorted_priority_queue.sv
// Testbench top for the sorted priority queue: stimulus, stalls and verdict.
`timescale 1ns / 1ps

module tb_sorted_priority_queue;
    import sprq_pkg::*;

    localparam int         DEPTH       = 16;
    localparam int         RAND_WORDS  = 1450;
    localparam int         CYCLE_LIMIT = 300000;
    localparam logic [1:0] MODE_IDLE   = 2'd3;   // unused code, block treats it as a no-op

    logic                 i_clk    = 1'b0;
    logic                 i_rst_n  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;        // mode[1:0], value[33:2], zero pad
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;              // out_value[31:0], status[33:32],
                                                // count[38:34], is_empty[39]

    int fail_count;
    int pending;
    int results;
    int full_drops;
    int empty_reads;
    int cycles = 0;

    always #2 i_clk = ~i_clk;

    sorted_priority_queue #(.DEPTH(DEPTH)) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    sprq_monitor #(.DEPTH(DEPTH)) monitor (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_results     (results),
        .o_full_drops  (full_drops),
        .o_empty_reads (empty_reads)
    );

    // Holds one word on the slave side until the block takes it. Leaves
    // tvalid high so a following word goes back to back.
    task automatic send_word(input logic [1:0] mode, input t_word value);
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, value, mode};
        do @(posedge i_clk); while (!s_tready);
    endtask

    // Mix of small values (lots of ties), both extremes and full-range values.
    function automatic t_word pick_value();
        case ($urandom_range(0, 5))
            0:       return $signed($urandom_range(0, 6)) - 3;
            1:       return 32'sh7fff_ffff;
            2:       return 32'sh8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Receiver: switches among always-ready, half, mostly stalled and
    // rarely stalled windows of random length.
    initial begin
        int stall_style;
        int span;
        forever begin
            stall_style = $urandom_range(0, 3);
            span        = $urandom_range(8, 80);
            repeat (span) begin
                @(posedge i_clk);
                case (stall_style)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 1) == 0);
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Stuck handshake guard
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int         sent;
        int         burst;
        int         phase_left;
        int         push_pct;
        int         roll;
        logic [1:0] mode;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reads on empty, no-op, both extremes, ties, fill to full
        send_word(MODE_POP, 32'sd0);
        send_word(MODE_PEEK, 32'sd0);
        send_word(MODE_IDLE, 32'shffff_ffff);
        send_word(MODE_PUSH, 32'sh7fff_ffff);
        send_word(MODE_PUSH, 32'sh8000_0000);
        send_word(MODE_PUSH, 32'sd0);
        send_word(MODE_PUSH, -32'sd1);
        send_word(MODE_PUSH, 32'sd0);
        send_word(MODE_PEEK, 32'sh1234_5678);
        send_word(MODE_IDLE, 32'sh5555_5555);
        send_word(MODE_POP, 32'sd0);
        send_word(MODE_POP, 32'sd0);
        // three held now; thirteen more fills the row
        repeat (DEPTH - 3) send_word(MODE_PUSH, pick_value());
        send_word(MODE_PUSH, 32'sh8000_0000);   // dropped, row is full
        send_word(MODE_IDLE, 32'shaaaa_aaaa);
        send_word(MODE_PEEK, 32'sd0);

        // Random: phases lean toward filling or draining so the row keeps
        // swinging between full and empty
        sent       = 0;
        phase_left = 0;
        push_pct   = 50;
        while (sent < RAND_WORDS) begin
            burst = $urandom_range(1, 24);
            repeat (burst) begin
                if (phase_left == 0) begin
                    case ($urandom_range(0, 2))
                        0:       push_pct = 75;
                        1:       push_pct = 25;
                        default: push_pct = 50;
                    endcase
                    phase_left = $urandom_range(15, 50);
                end
                phase_left--;
                roll = $urandom_range(0, 99);
                if (roll < 4)
                    mode = MODE_IDLE;
                else if (roll < 16)
                    mode = MODE_PEEK;
                else if ($urandom_range(0, 99) < push_pct)
                    mode = MODE_PUSH;
                else
                    mode = MODE_POP;
                send_word(mode, (mode == MODE_PUSH) ? pick_value() : t_word'($urandom));
                if (mode != MODE_IDLE)
                    sent++;
            end
            // a quarter of bursts run straight into the next one
            if ($urandom_range(0, 3) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
        s_tvalid <= 1'b0;

        // drain, then a few quiet cycles to catch stray result words
        do @(negedge i_clk); while (pending != 0);
        repeat (10) @(negedge i_clk);

        $display("checked %0d result words over %0d random operations plus a directed opener",
                 results, sent);
        $display("%0d pushes hit a full queue, %0d pops or peeks hit an empty one",
                 full_drops, empty_reads);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
